>>> hdl/ansi_sgr_stream_parser_unit_macros.svh
// Assertion macros for the ANSI SGR stream parser unit.
// Bodies use the clk and arst_n names of the including module.
`ifndef ANSI_SGR_STREAM_PARSER_UNIT_MACROS_SVH
`define ANSI_SGR_STREAM_PARSER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASP_ASSERT_IMP(label, ante, cons, msg)
`define ASP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/asp_pkg.sv
// Shared types, constants and the SGR decode function of the stream parser.
// No dependencies.
`default_nettype none
package asp_pkg;

	localparam int BODY_MAX = 30;
	localparam int CNT_W    = $clog2(BODY_MAX + 1);
	localparam int IDX_W    = $clog2(BODY_MAX);
	localparam int VAL_W    = 31;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [VAL_W-1:0] VALUE_LIMIT = '1;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_M      = 8'h6D;

	localparam logic [VAL_W-1:0] SGR_RESET      = 31'd0;
	localparam logic [VAL_W-1:0] SGR_BOLD       = 31'd1;
	localparam logic [VAL_W-1:0] SGR_ITALIC     = 31'd3;
	localparam logic [VAL_W-1:0] SGR_UNDER      = 31'd4;
	localparam logic [VAL_W-1:0] SGR_INVERSE    = 31'd7;
	localparam logic [VAL_W-1:0] SGR_NO_BOLD    = 31'd22;
	localparam logic [VAL_W-1:0] SGR_NO_ITALIC  = 31'd23;
	localparam logic [VAL_W-1:0] SGR_NO_UNDER   = 31'd24;
	localparam logic [VAL_W-1:0] SGR_NO_INVERSE = 31'd27;
	localparam logic [VAL_W-1:0] SGR_FG_LO      = 31'd30;
	localparam logic [VAL_W-1:0] SGR_FG_HI      = 31'd37;
	localparam logic [VAL_W-1:0] SGR_FG_DEF     = 31'd39;
	localparam logic [VAL_W-1:0] SGR_BG_LO      = 31'd40;
	localparam logic [VAL_W-1:0] SGR_BG_HI      = 31'd47;
	localparam logic [VAL_W-1:0] SGR_BG_DEF     = 31'd49;
	localparam logic [VAL_W-1:0] SGR_FGB_LO     = 31'd90;
	localparam logic [VAL_W-1:0] SGR_FGB_HI     = 31'd97;
	localparam logic [VAL_W-1:0] SGR_BGB_LO     = 31'd100;
	localparam logic [VAL_W-1:0] SGR_BGB_HI     = 31'd107;

	localparam logic [4:0] COLOR_DEFAULT = 5'd16;
	localparam logic [4:0] COLOR_BRIGHT  = 5'd8;

	typedef struct packed {
		logic [4:0] bg;
		logic [4:0] fg;
		logic       inverse;
		logic       underline;
		logic       italic;
		logic       bold;
	} fmt_t;

	localparam fmt_t FMT_RESET = '{bg: COLOR_DEFAULT, fg: COLOR_DEFAULT,
		inverse: 1'b0, underline: 1'b0, italic: 1'b0, bold: 1'b0};

	typedef enum logic {CMD_CHAR, CMD_REPLAY} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             cvalid;
		logic [7:0]       ch;
		logic [CNT_W-1:0] count;
		fmt_t             fmt;
		logic             esc;
		logic             done;
	} cmd_t;

	typedef struct packed {
		logic push0;
		logic push1;
		cmd_t cmd0;
		cmd_t cmd1;
	} q_wr_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} queue_status_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} buf_wr_t;

	typedef struct packed {
		logic replaying;
		logic replay_done;
	} back_status_t;

	typedef struct packed {
		logic over;
		logic bad;
		logic trail;
		logic digit;
	} part_flags_t;

	function automatic fmt_t apply_sgr(fmt_t f, logic [VAL_W-1:0] v);
		fmt_t r;
		r = f;
		if (v == SGR_RESET) r = FMT_RESET;
		else if (v == SGR_BOLD) r.bold = 1'b1;
		else if (v == SGR_ITALIC) r.italic = 1'b1;
		else if (v == SGR_UNDER) r.underline = 1'b1;
		else if (v == SGR_INVERSE) r.inverse = 1'b1;
		else if (v == SGR_NO_BOLD) r.bold = 1'b0;
		else if (v == SGR_NO_ITALIC) r.italic = 1'b0;
		else if (v == SGR_NO_UNDER) r.underline = 1'b0;
		else if (v == SGR_NO_INVERSE) r.inverse = 1'b0;
		else if (v >= SGR_FG_LO && v <= SGR_FG_HI) r.fg = 5'(v - SGR_FG_LO);
		else if (v == SGR_FG_DEF) r.fg = COLOR_DEFAULT;
		else if (v >= SGR_BG_LO && v <= SGR_BG_HI) r.bg = 5'(v - SGR_BG_LO);
		else if (v == SGR_BG_DEF) r.bg = COLOR_DEFAULT;
		else if (v >= SGR_FGB_LO && v <= SGR_FGB_HI)
			r.fg = 5'(v - SGR_FGB_LO) | COLOR_BRIGHT;
		else if (v >= SGR_BGB_LO && v <= SGR_BGB_HI)
			r.bg = 5'(v - SGR_BGB_LO) | COLOR_BRIGHT;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/asp_in_if.sv
// Input byte channel of the stream parser: valid, ready, one stream byte and an end-of-message flag.
// No dependencies.
`default_nettype none
interface asp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_message;

	modport source (output valid, ch, end_of_message, input ready);
	modport sink (input valid, ch, end_of_message, output ready);
endinterface
`default_nettype wire

>>> hdl/asp_out_if.sv
// Output channel of the stream parser: at most one formatted text byte per beat.
// No dependencies.
`default_nettype none
interface asp_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] text_char;
	logic       bold;
	logic       italic;
	logic       underline;
	logic       inverse;
	logic [4:0] fg_color;
	logic [4:0] bg_color;
	logic       escape_seen;
	logic       message_done;

	modport source (output valid, char_valid, text_char, bold, italic, underline, inverse,
		fg_color, bg_color, escape_seen, message_done, input ready);
	modport sink (input valid, char_valid, text_char, bold, italic, underline, inverse,
		fg_color, bg_color, escape_seen, message_done, output ready);
endinterface
`default_nettype wire

>>> hdl/asp_front.sv
// Front end: accepts stream bytes, tracks escape and SGR parse state, pushes
// output commands into the queue and writes the replay buffer. Uses asp_pkg.
`default_nettype none
module asp_front import asp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	asp_in_if.sink             bytes,
	input  wire queue_status_t q_st,
	input  wire back_status_t  bk_st,
	output q_wr_t              q_wr,
	output buf_wr_t            buf_wr
);

	typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_BODY} phase_t;

	phase_t           phase_q, phase_n;
	fmt_t             live_q, live_n;
	fmt_t             shadow_q, shadow_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [VAL_W-1:0] pval_q, pval_n;
	part_flags_t      pf_q, pf_n;
	logic             kept_q, kept_n;
	logic             esc_q, esc_n;
	logic             busy_q, busy_n;

	logic             accept;
	logic             is_letter;
	logic             is_body;
	logic             keep_part;
	fmt_t             shadow_closed;
	logic [VAL_W+3:0] next_val;
	logic             val_over;
	logic [1:0]       n_cmd;
	cmd_t             cmds [2];
	fmt_t             fmt_out;
	logic             esc_out;

	function automatic cmd_t mk_cmd(cmd_kind_t k, logic cv, logic [7:0] c,
		logic [CNT_W-1:0] cnt);
		cmd_t r;
		r = '0;
		r.kind   = k;
		r.cvalid = cv;
		r.ch     = c;
		r.count  = cnt;
		return r;
	endfunction

	assign bytes.ready = !busy_q && (q_st.count <= QCNT_W'(QDEPTH - 2));
	assign accept      = bytes.valid && bytes.ready;

	assign is_letter = (bytes.ch >= CH_UA && bytes.ch <= CH_UZ) ||
		(bytes.ch >= CH_LA && bytes.ch <= CH_LZ);
	assign is_body   = (bytes.ch >= CH_ZERO && bytes.ch <= CH_NINE) ||
		bytes.ch == CH_SEMI || bytes.ch == CH_SPACE;

	assign keep_part     = pf_q.digit && !pf_q.bad && !pf_q.over;
	assign shadow_closed = keep_part ? apply_sgr(shadow_q, pval_q) : shadow_q;
	assign next_val      = {1'b0, pval_q, 3'b000} + {3'b000, pval_q, 1'b0} +
		{{(VAL_W){1'b0}}, bytes.ch[3:0]};
	assign val_over      = next_val > {4'b0000, VALUE_LIMIT};

	always_comb begin
		phase_n  = phase_q;
		live_n   = live_q;
		shadow_n = shadow_q;
		cnt_n    = cnt_q;
		pval_n   = pval_q;
		pf_n     = pf_q;
		kept_n   = kept_q;
		esc_n    = esc_q;
		busy_n   = busy_q;
		n_cmd    = 2'd0;
		cmds[0]  = '0;
		cmds[1]  = '0;
		buf_wr   = '0;
		fmt_out  = live_q;
		esc_out  = esc_q;
		if (bk_st.replay_done) busy_n = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_ESC: begin
					if (bytes.ch == CH_LBRACK) begin
						esc_n    = 1'b1;
						cnt_n    = '0;
						pval_n   = '0;
						pf_n     = '0;
						kept_n   = 1'b0;
						shadow_n = live_q;
						phase_n  = PH_BODY;
					end else begin
						cmds[0] = mk_cmd(CMD_CHAR, 1'b1, CH_ESC, '0);
						n_cmd   = 2'd1;
						if (bytes.ch == CH_ESC) begin
							phase_n = PH_ESC;
						end else begin
							cmds[1] = mk_cmd(CMD_CHAR, 1'b1, bytes.ch, '0);
							n_cmd   = 2'd2;
							phase_n = PH_IDLE;
						end
					end
				end
				PH_BODY: begin
					if (is_letter) begin
						shadow_n = shadow_closed;
						if (bytes.ch == CH_M)
							live_n = (kept_q || keep_part) ? shadow_closed : FMT_RESET;
						cnt_n   = '0;
						pval_n  = '0;
						pf_n    = '0;
						kept_n  = 1'b0;
						phase_n = PH_IDLE;
					end else if (is_body && cnt_q < CNT_W'(BODY_MAX)) begin
						buf_wr.we   = 1'b1;
						buf_wr.addr = cnt_q[IDX_W-1:0];
						buf_wr.data = bytes.ch;
						cnt_n       = cnt_q + CNT_W'(1);
						if (bytes.ch == CH_SEMI) begin
							shadow_n = shadow_closed;
							kept_n   = kept_q || keep_part;
							pval_n   = '0;
							pf_n     = '0;
						end else if (bytes.ch == CH_SPACE) begin
							if (pf_q.digit) pf_n.trail = 1'b1;
						end else begin
							pf_n.digit = 1'b1;
							pf_n.bad   = pf_q.bad || pf_q.trail;
							pf_n.over  = pf_q.over || val_over;
							pval_n     = val_over ? VALUE_LIMIT : next_val[VAL_W-1:0];
						end
					end else begin
						cmds[0] = mk_cmd(CMD_REPLAY, 1'b1, CH_LBRACK, cnt_q);
						n_cmd   = 2'd1;
						cnt_n   = '0;
						pval_n  = '0;
						pf_n    = '0;
						kept_n  = 1'b0;
						if (bytes.ch == CH_ESC) begin
							phase_n = PH_ESC;
						end else begin
							cmds[1] = mk_cmd(CMD_CHAR, 1'b1, bytes.ch, '0);
							n_cmd   = 2'd2;
							phase_n = PH_IDLE;
						end
					end
				end
				PH_IDLE: begin
					if (bytes.ch == CH_ESC) begin
						phase_n = PH_ESC;
					end else begin
						cmds[0] = mk_cmd(CMD_CHAR, 1'b1, bytes.ch, '0);
						n_cmd   = 2'd1;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
			fmt_out = live_n;
			esc_out = esc_n;
			if (bytes.end_of_message) begin
				if (phase_n == PH_ESC) begin
					cmds[n_cmd[0]] = mk_cmd(CMD_CHAR, 1'b1, CH_ESC, '0);
					n_cmd          = n_cmd + 2'd1;
				end else if (phase_n == PH_BODY) begin
					cmds[n_cmd[0]] = mk_cmd(CMD_REPLAY, 1'b1, CH_LBRACK, cnt_n);
					n_cmd          = n_cmd + 2'd1;
				end
				if (n_cmd == 2'd0) begin
					cmds[0] = mk_cmd(CMD_CHAR, 1'b0, 8'h00, '0);
					n_cmd   = 2'd1;
				end
				if (n_cmd == 2'd2) cmds[1].done = 1'b1;
				else cmds[0].done = 1'b1;
				live_n   = FMT_RESET;
				shadow_n = FMT_RESET;
				esc_n    = 1'b0;
				cnt_n    = '0;
				pval_n   = '0;
				pf_n     = '0;
				kept_n   = 1'b0;
				phase_n  = PH_IDLE;
			end
			cmds[0].fmt = fmt_out;
			cmds[0].esc = esc_out;
			cmds[1].fmt = fmt_out;
			cmds[1].esc = esc_out;
			if ((n_cmd != 2'd0 && cmds[0].kind == CMD_REPLAY) ||
				(n_cmd == 2'd2 && cmds[1].kind == CMD_REPLAY))
				busy_n = 1'b1;
		end
	end

	assign q_wr.push0 = n_cmd != 2'd0;
	assign q_wr.push1 = n_cmd == 2'd2;
	assign q_wr.cmd0  = cmds[0];
	assign q_wr.cmd1  = cmds[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			live_q   <= FMT_RESET;
			shadow_q <= FMT_RESET;
			cnt_q    <= '0;
			pval_q   <= '0;
			pf_q     <= '0;
			kept_q   <= 1'b0;
			esc_q    <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			live_q   <= live_n;
			shadow_q <= shadow_n;
			cnt_q    <= cnt_n;
			pval_q   <= pval_n;
			pf_q     <= pf_n;
			kept_q   <= kept_n;
			esc_q    <= esc_n;
			busy_q   <= busy_n;
		end
	end

endmodule
`default_nettype wire

>>> hdl/asp_cmd_queue.sv
// Command queue between front and back end: two writes, one read per cycle.
// Depth QDEPTH must be a power of two. Uses asp_pkg.
`default_nettype none
module asp_cmd_queue import asp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_wr_t    wr,
	input  wire logic     pop,
	output cmd_t          head,
	output queue_status_t st
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] n_in;

	assign n_in     = QCNT_W'(wr.push0) + QCNT_W'(wr.push1);
	assign head     = mem_q[rd_ptr_q];
	assign st.count = count_q;
	assign st.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (wr.push0) mem_q[wr_ptr_q] <= wr.cmd0;
		if (wr.push1) mem_q[wr_ptr_q + QPTR_W'(1)] <= wr.cmd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_in[QPTR_W-1:0];
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + n_in - QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

>>> hdl/asp_back.sv
// Back end: pops commands, replays buffered sequence bodies and drives the
// registered output channel. Holds the replay buffer. Uses asp_pkg.
`default_nettype none
module asp_back import asp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          head,
	input  wire queue_status_t q_st,
	output logic               pop,
	input  wire buf_wr_t       buf_wr,
	output back_status_t       st,
	asp_out_if.source          cells
);

	typedef enum logic {BK_FETCH, BK_REPLAY} bk_state_t;

	bk_state_t        state_q;
	logic [7:0]       buf_q [BODY_MAX];
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] rcnt_q;
	fmt_t             rfmt_q;
	logic             resc_q;
	logic             rdone_q;

	logic             ovalid_q;
	logic             cvalid_q;
	logic [7:0]       ch_q;
	fmt_t             ofmt_q;
	logic             oesc_q;
	logic             odone_q;

	logic             load;
	logic             last;

	assign load = !ovalid_q || cells.ready;
	assign pop  = state_q == BK_FETCH && load && !q_st.empty;
	assign last = CNT_W'(idx_q) + CNT_W'(1) == rcnt_q;

	assign st.replaying   = state_q == BK_REPLAY;
	assign st.replay_done = (pop && head.kind == CMD_REPLAY && head.count == '0) ||
		(state_q == BK_REPLAY && load && last);

	assign cells.valid        = ovalid_q;
	assign cells.char_valid   = cvalid_q;
	assign cells.text_char    = ch_q;
	assign cells.bold         = ofmt_q.bold;
	assign cells.italic       = ofmt_q.italic;
	assign cells.underline    = ofmt_q.underline;
	assign cells.inverse      = ofmt_q.inverse;
	assign cells.fg_color     = ofmt_q.fg;
	assign cells.bg_color     = ofmt_q.bg;
	assign cells.escape_seen  = oesc_q;
	assign cells.message_done = odone_q;

	always_ff @(posedge clk) begin
		if (buf_wr.we) buf_q[buf_wr.addr] <= buf_wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_FETCH;
			idx_q    <= '0;
			rcnt_q   <= '0;
			rfmt_q   <= FMT_RESET;
			resc_q   <= 1'b0;
			rdone_q  <= 1'b0;
			ovalid_q <= 1'b0;
			cvalid_q <= 1'b0;
			ch_q     <= '0;
			ofmt_q   <= FMT_RESET;
			oesc_q   <= 1'b0;
			odone_q  <= 1'b0;
		end else if (load) begin
			unique case (state_q)
				BK_FETCH: begin
					ovalid_q <= pop;
					if (pop) begin
						cvalid_q <= head.cvalid;
						ch_q     <= head.ch;
						ofmt_q   <= head.fmt;
						oesc_q   <= head.esc;
						odone_q  <= head.done &&
							(head.kind == CMD_CHAR || head.count == '0);
						if (head.kind == CMD_REPLAY && head.count != '0) begin
							state_q <= BK_REPLAY;
							idx_q   <= '0;
							rcnt_q  <= head.count;
							rfmt_q  <= head.fmt;
							resc_q  <= head.esc;
							rdone_q <= head.done;
						end
					end
				end
				BK_REPLAY: begin
					ovalid_q <= 1'b1;
					cvalid_q <= 1'b1;
					ch_q     <= buf_q[idx_q];
					ofmt_q   <= rfmt_q;
					oesc_q   <= resc_q;
					odone_q  <= rdone_q && last;
					idx_q    <= idx_q + IDX_W'(1);
					if (last) state_q <= BK_FETCH;
				end
				default: state_q <= BK_FETCH;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/ansi_sgr_stream_parser_unit.sv
// Top level of the ANSI SGR stream parser: front end, command queue, back end.
// Depends on asp_pkg, asp_in_if, asp_out_if, asp_front, asp_cmd_queue, asp_back.
//
//  channel    dir  beat contents
//  byte_chan  in   ch, end_of_message
//  cell_chan  out  char_valid, text_char, format flags, colours, escape_seen,
//                  message_done
//
// One byte is taken per cycle while the queue has two free slots; the back end
// sends one result per cycle from its output register while the receiver is
// ready, so throughput follows the number of results a byte causes. A replayed
// body (ESC '[' aborted or flushed) holds the input until the back end has read
// the last buffered byte, read through the single replay buffer read port.
// Reset clears control state only; the replay buffer is never cleared.
`default_nettype none
`include "ansi_sgr_stream_parser_unit_macros.svh"
module ansi_sgr_stream_parser_unit import asp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	asp_in_if.sink    byte_chan,
	asp_out_if.source cell_chan
);

	q_wr_t         q_wr;
	queue_status_t q_st;
	cmd_t          q_head;
	logic          q_pop;
	buf_wr_t       buf_wr;
	back_status_t  bk_st;
	logic          replay_pop;

	asp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_chan),
		.q_st   (q_st),
		.bk_st  (bk_st),
		.q_wr   (q_wr),
		.buf_wr (buf_wr)
	);

	asp_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.head   (q_head),
		.st     (q_st)
	);

	asp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_st   (q_st),
		.pop    (q_pop),
		.buf_wr (buf_wr),
		.st     (bk_st),
		.cells  (cell_chan)
	);

	assign replay_pop = q_pop && q_head.kind == CMD_REPLAY && q_head.count != '0;

	`ASP_ASSERT_IMP(a_two_slots, q_wr.push1, q_st.count <= QCNT_W'(QDEPTH - 2), "queue overrun")
	`ASP_ASSERT_IMP(a_hold_in_replay, bk_st.replaying, !byte_chan.ready, "input in replay")
	`ASP_ASSERT_IMP(a_buf_quiet, buf_wr.we, !bk_st.replaying, "buffer written in replay")
	`ASP_ASSERT_NXT(a_replay_start, replay_pop, bk_st.replaying, "replay not started")

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ansi_sgr_stream_parser_unit: a byte driver, a cell monitor and an
// SGR escape predictor that checks every output beat field by field.
// Depends on asp_pkg, asp_in_if, asp_out_if and the parser RTL.
module tb_top;
	import asp_pkg::*;

	typedef enum logic [1:0] {PS_TEXT, PS_ESC, PS_BODY} parse_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eom;
	} stim_t;

	typedef struct packed {
		logic       cv;
		logic [7:0] ch;
		fmt_t       fmt;
		logic       esc;
		logic       done;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n;

	asp_in_if  byte_chan ();
	asp_out_if cell_chan ();

	ansi_sgr_stream_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_chan(byte_chan),
		.cell_chan(cell_chan)
	);

	always #10 clk = ~clk;

	stim_t        pending[$];
	stim_t        next_beat;
	cell_t        exp_cells[$];
	logic [7:0]   msg[$];
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	int unsigned  err_count;
	int unsigned  bytes_queued;

	// predictor state
	parse_state_t ps;
	fmt_t         live_fmt;
	fmt_t         shadow_fmt;
	logic [7:0]   body_buf[BODY_MAX];
	int unsigned  body_len;
	int unsigned  param_val;
	part_flags_t  pf;
	logic         any_kept;
	logic         esc_seen;
	int unsigned  cells_this_byte;

	cell_t        want;
	int unsigned  got_v[10];
	int unsigned  want_v[10];
	string        cell_field[10] = '{"char_valid", "text_char", "bold", "italic", "underline",
		"inverse", "fg_color", "bg_color", "escape_seen", "message_done"};

	function automatic bit is_letter(logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic bit is_body(logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI || c == CH_SPACE;
	endfunction

	function automatic fmt_t sgr_fold(fmt_t f, int unsigned code);
		fmt_t r;
		r = f;
		if (code == SGR_RESET) r = FMT_RESET;
		else if (code == SGR_BOLD) r.bold = 1'b1;
		else if (code == SGR_ITALIC) r.italic = 1'b1;
		else if (code == SGR_UNDER) r.underline = 1'b1;
		else if (code == SGR_INVERSE) r.inverse = 1'b1;
		else if (code == SGR_NO_BOLD) r.bold = 1'b0;
		else if (code == SGR_NO_ITALIC) r.italic = 1'b0;
		else if (code == SGR_NO_UNDER) r.underline = 1'b0;
		else if (code == SGR_NO_INVERSE) r.inverse = 1'b0;
		else if (code == SGR_FG_DEF) r.fg = COLOR_DEFAULT;
		else if (code == SGR_BG_DEF) r.bg = COLOR_DEFAULT;
		else if (code >= SGR_FG_LO && code <= SGR_FG_HI) r.fg = 5'(code - SGR_FG_LO);
		else if (code >= SGR_BG_LO && code <= SGR_BG_HI) r.bg = 5'(code - SGR_BG_LO);
		else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI)
			r.fg = 5'(code - SGR_FGB_LO + COLOR_BRIGHT);
		else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI)
			r.bg = 5'(code - SGR_BGB_LO + COLOR_BRIGHT);
		return r;
	endfunction

	function automatic void push_cell(logic cv, logic [7:0] c);
		cell_t e;
		e.cv   = cv;
		e.ch   = c;
		e.fmt  = live_fmt;
		e.esc  = esc_seen;
		e.done = 1'b0;
		exp_cells.push_back(e);
		cells_this_byte++;
	endfunction

	function automatic void clear_params();
		body_len  = 0;
		param_val = 0;
		pf        = '0;
		any_kept  = 1'b0;
	endfunction

	function automatic void close_param();
		if (pf.digit && !pf.bad && !pf.over) begin
			shadow_fmt = sgr_fold(shadow_fmt, param_val);
			any_kept   = 1'b1;
		end
		param_val = 0;
		pf        = '0;
	endfunction

	function automatic void take_param_byte(logic [7:0] c);
		longint unsigned nv;
		if (c == CH_SEMI) begin
			close_param();
		end else if (c == CH_SPACE) begin
			if (pf.digit) pf.trail = 1'b1;
		end else begin
			if (pf.trail) pf.bad = 1'b1;
			pf.digit = 1'b1;
			nv = longint'(param_val) * 10 + longint'(c - CH_ZERO);
			if (nv > VALUE_LIMIT) begin
				pf.over = 1'b1;
				nv = VALUE_LIMIT;
			end
			param_val = int'(nv);
		end
	endfunction

	function automatic void text_byte(logic [7:0] c);
		if (c == CH_ESC) ps = PS_ESC;
		else push_cell(1'b1, c);
	endfunction

	function automatic void flush_body();
		push_cell(1'b1, CH_LBRACK);
		for (int i = 0; i < body_len; i++)
			push_cell(1'b1, body_buf[i]);
		clear_params();
		ps = PS_TEXT;
	endfunction

	function automatic void predict_byte(logic [7:0] c, logic eom);
		cell_t last;
		cells_this_byte = 0;
		case (ps)
			PS_ESC: begin
				if (c == CH_LBRACK) begin
					esc_seen = 1'b1;
					clear_params();
					shadow_fmt = live_fmt;
					ps = PS_BODY;
				end else begin
					ps = PS_TEXT;
					push_cell(1'b1, CH_ESC);
					text_byte(c);
				end
			end
			PS_BODY: begin
				if (is_letter(c)) begin
					close_param();
					if (c == CH_M) live_fmt = any_kept ? shadow_fmt : FMT_RESET;
					clear_params();
					ps = PS_TEXT;
				end else if (is_body(c) && body_len < BODY_MAX) begin
					body_buf[body_len] = c;
					body_len++;
					take_param_byte(c);
				end else begin
					flush_body();
					text_byte(c);
				end
			end
			default: text_byte(c);
		endcase
		if (eom) begin
			if (ps == PS_ESC) begin
				push_cell(1'b1, CH_ESC);
				ps = PS_TEXT;
			end else if (ps == PS_BODY) begin
				flush_body();
			end
			if (cells_this_byte == 0) push_cell(1'b0, 8'h00);
			last = exp_cells.pop_back();
			last.done = 1'b1;
			exp_cells.push_back(last);
			live_fmt   = FMT_RESET;
			shadow_fmt = FMT_RESET;
			esc_seen   = 1'b0;
			clear_params();
			ps = PS_TEXT;
		end
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// driver: hold a beat until it is taken, idle at random between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_chan.valid          <= 1'b0;
			byte_chan.ch             <= '0;
			byte_chan.end_of_message <= 1'b0;
		end else if (!byte_chan.valid || byte_chan.ready) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = pending.pop_front();
				byte_chan.valid          <= 1'b1;
				byte_chan.ch             <= next_beat.ch;
				byte_chan.end_of_message <= next_beat.eom;
			end else begin
				byte_chan.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_chan.ready <= 1'b0;
		end else begin
			cell_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on every accepted byte, then check the output beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_chan.valid && byte_chan.ready)
				predict_byte(byte_chan.ch, byte_chan.end_of_message);
			if (cell_chan.valid && cell_chan.ready) begin
				if (exp_cells.size() == 0) begin
					report($sformatf("unexpected beat, text_char %02h", cell_chan.text_char));
				end else begin
					want = exp_cells.pop_front();
					got_v  = '{cell_chan.char_valid, cell_chan.text_char, cell_chan.bold,
						cell_chan.italic, cell_chan.underline, cell_chan.inverse,
						cell_chan.fg_color, cell_chan.bg_color, cell_chan.escape_seen,
						cell_chan.message_done};
					want_v = '{want.cv, want.ch, want.fmt.bold, want.fmt.italic,
						want.fmt.underline, want.fmt.inverse, want.fmt.fg, want.fmt.bg,
						want.esc, want.done};
					for (int i = 0; i < 10; i++)
						if (got_v[i] != want_v[i])
							report($sformatf("%s got %0d want %0d", cell_field[i],
								got_v[i], want_v[i]));
				end
			end
		end
	end

	task automatic push_byte(logic [7:0] c, logic eom);
		stim_t s;
		s.ch  = c;
		s.eom = eom;
		pending.push_back(s);
	endtask

	task automatic push_text(string s, logic eom);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], eom && i == s.len() - 1);
	endtask

	task automatic add_num(int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endtask

	task automatic add_spaces();
		repeat ($urandom_range(2)) msg.push_back(CH_SPACE);
	endtask

	function automatic int unsigned pick_sgr_code();
		case ($urandom_range(13))
			0: return SGR_RESET;
			1: return SGR_BOLD;
			2: return SGR_ITALIC;
			3: return SGR_UNDER;
			4: return SGR_INVERSE;
			5: return SGR_NO_BOLD + $urandom_range(SGR_NO_UNDER - SGR_NO_BOLD);
			6: return SGR_NO_INVERSE;
			7: return SGR_FG_LO + $urandom_range(SGR_FG_HI - SGR_FG_LO);
			8: return $urandom_range(1) ? SGR_FG_DEF : SGR_BG_DEF;
			9: return SGR_BG_LO + $urandom_range(SGR_BG_HI - SGR_BG_LO);
			10: return SGR_FGB_LO + $urandom_range(SGR_FGB_HI - SGR_FGB_LO);
			11: return SGR_BGB_LO + $urandom_range(SGR_BGB_HI - SGR_BGB_LO);
			default: return $urandom_range(120);
		endcase
	endfunction

	task automatic add_param();
		case ($urandom_range(19))
			12: ;
			13: begin
				add_num($urandom_range(1, 9));
				msg.push_back(CH_SPACE);
				add_num($urandom_range(9));
			end
			14: add_num(VALUE_LIMIT);
			15: add_num(int'(VALUE_LIMIT) + 1);
			16: repeat ($urandom_range(10, 13)) msg.push_back(8'(CH_ZERO + $urandom_range(9)));
			17: begin
				repeat ($urandom_range(1, 3)) msg.push_back(CH_ZERO);
				add_num(pick_sgr_code());
			end
			18, 19: add_spaces();
			default: begin
				add_spaces();
				add_num(pick_sgr_code());
				add_spaces();
			end
		endcase
	endtask

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(3) != 0) return CH_M;
		if ($urandom_range(1)) return 8'(CH_UA + $urandom_range(CH_UZ - CH_UA));
		return 8'(CH_LA + $urandom_range(CH_LZ - CH_LA));
	endfunction

	function automatic logic [7:0] pick_body_byte();
		case ($urandom_range(5))
			0: return CH_SEMI;
			1: return CH_SPACE;
			default: return 8'(CH_ZERO + $urandom_range(9));
		endcase
	endfunction

	task automatic add_segment();
		int unsigned k;
		logic [7:0]  c;
		k = $urandom_range(99);
		if (k < 45) begin
			msg.push_back(CH_ESC);
			msg.push_back(CH_LBRACK);
			for (int i = $urandom_range(4); i > 0; i--) begin
				add_param();
				if (i > 1) msg.push_back(CH_SEMI);
			end
			msg.push_back(pick_letter());
		end else if (k < 65) begin
			repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(CH_SPACE, 126)));
		end else if (k < 75) begin
			msg.push_back(CH_ESC);
			msg.push_back(8'($urandom_range(255)));
		end else if (k < 85) begin
			msg.push_back(CH_ESC);
			msg.push_back(CH_LBRACK);
			repeat ($urandom_range(5)) msg.push_back(pick_body_byte());
			do c = 8'($urandom_range(255)); while (is_body(c) || is_letter(c));
			msg.push_back(c);
		end else if (k < 90) begin
			msg.push_back(CH_ESC);
			msg.push_back(CH_LBRACK);
			repeat ($urandom_range(BODY_MAX, BODY_MAX + 3)) msg.push_back(pick_body_byte());
			msg.push_back($urandom_range(1) ? CH_M : pick_body_byte());
		end else begin
			msg.push_back(8'($urandom_range(255)));
		end
	endtask

	// cut some messages short so that the end lands inside a sequence
	task automatic commit_msg();
		int unsigned cut;
		cut = msg.size();
		if ($urandom_range(99) < 15) cut = $urandom_range(1, msg.size());
		for (int i = 0; i < cut; i++)
			push_byte(msg[i], i == cut - 1);
		msg.delete();
		bytes_queued += cut;
	endtask

	task automatic queue_random(int unsigned n);
		bytes_queued = 0;
		while (bytes_queued < n) begin
			repeat ($urandom_range(1, 6)) add_segment();
			commit_msg();
		end
	endtask

	task automatic drain_pending();
		while (pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n                   = 1'b0;
		byte_chan.valid          = 1'b0;
		byte_chan.ch             = '0;
		byte_chan.end_of_message = 1'b0;
		cell_chan.ready          = 1'b0;
		send_idle_pct            = 0;
		recv_stall_pct           = 0;
		err_count                = 0;
		ps                       = PS_TEXT;
		live_fmt                 = FMT_RESET;
		shadow_fmt               = FMT_RESET;
		esc_seen                 = 1'b0;
		clear_params();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_text("A", 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_text("x", 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRACK, 1'b0);
		push_text("1;31mB", 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRACK, 1'b0);
		push_text("2!", 1'b0);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRACK, 1'b0);
		push_text("m", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_ESC, 1'b1);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRACK, 1'b0);
		push_text("7", 1'b1);
		push_byte(CH_ESC, 1'b0);
		push_byte(CH_LBRACK, 1'b0);
		push_text("H", 1'b1);
		queue_random(70);
		drain_pending();

		send_idle_pct = 65;
		queue_random(70);
		drain_pending();

		send_idle_pct  = 0;
		recv_stall_pct = 65;
		queue_random(70);
		drain_pending();

		send_idle_pct  = 11;
		recv_stall_pct = 11;
		queue_random(70);
		drain_pending();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (pending.size() != 0 || byte_chan.valid || exp_cells.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
